// ===== src/smqp_pkg.sv =====
// Shared types, sizes and codes for the stack and multi-queue pool.
// No dependencies; imported by smqp_qtable and the top module.
package smqp_pkg;

    // Pool geometry (queue count is a power of two: the queue number is
    // reduced by dropping its upper bits)
    localparam int NUM_QUEUES  = 32;
    localparam int POOL_NODES  = 1024;
    localparam int VALUE_WIDTH = 32;

    localparam int PTR_W    = $clog2(POOL_NODES);
    localparam int CNT_W    = $clog2(POOL_NODES + 1);
    localparam int QSEL_W   = $clog2(NUM_QUEUES);
    localparam int DATA_W   = 32;
    localparam int QIDX_W   = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef logic [PTR_W-1:0]       t_ptr;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [QSEL_W-1:0]      t_qsel;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_ENQ  = 2'd2,
        OP_DEQ  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_STACK_EMPTY = 2'd1,
        ST_QUEUE_EMPTY = 2'd2,
        ST_POOL_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    // One queue descriptor as read from the queue table
    typedef struct packed {
        logic nonempty;
        t_ptr head;
        t_ptr tail;
    } t_qentry;

    // Update request to the queue table
    typedef struct packed {
        logic wr_head;
        logic wr_tail;
        logic set_ne;
        logic clr_ne;
        t_ptr head;
        t_ptr tail;
    } t_qupdate;

    // Input value to node width (zero-extended when the node is wider)
    function automatic t_val to_node(input logic [DATA_W-1:0] v);
        logic [63:0] w;
        w = {32'b0, v};
        return w[VALUE_WIDTH-1:0];
    endfunction

    // Node value back to the 32-bit result, sign-extended from node width
    function automatic logic [DATA_W-1:0] widen(input t_val v);
        logic [63:0] w;
        w = 64'($signed(v));
        return w[DATA_W-1:0];
    endfunction

endpackage

// ===== src/smqp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smqp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/smqp_qtable.sv =====
// Queue descriptor table: head, tail and nonempty flag per queue.
// Depends on smqp_pkg.
module smqp_qtable
    import smqp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_qsel    i_addr,
    input  t_qupdate i_upd,
    output t_qentry  o_entry
);

    t_ptr                  r_head [NUM_QUEUES];
    t_ptr                  r_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_nonempty;

    // pointers: written only once a queue is used, no reset
    always_ff @(posedge i_clk) begin
        if (i_upd.wr_head) begin
            r_head[i_addr] <= i_upd.head;
        end
        if (i_upd.wr_tail) begin
            r_tail[i_addr] <= i_upd.tail;
        end
    end

    // nonempty flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
        end else if (i_upd.set_ne) begin
            r_nonempty[i_addr] <= 1'b1;
        end else if (i_upd.clr_ne) begin
            r_nonempty[i_addr] <= 1'b0;
        end
    end

    assign o_entry.nonempty = r_nonempty[i_addr];
    assign o_entry.head     = r_head[i_addr];
    assign o_entry.tail     = r_tail[i_addr];

endmodule

// ===== src/stack_and_multi_queue_pool_top.sv =====
// One stack and NUM_QUEUES FIFO queues kept as linked lists in a shared node pool.
// The node memories are read in the accept cycle of a transaction; the dependent
// pointer updates, memory writes and the result follow in the execute state, which
// waits until the output register is free. An enqueue into a queue that already
// holds values goes on to a link state for the second write to the link memory
// (old tail to new node). The next transaction is taken once the previous one has
// finished; a finished result sits in an output register, so the block accepts new
// work while the result waits to be taken. No clearing pass after reset:
// never-used nodes are handed out by a fill counter.
// Depends on smqp_pkg, smqp_ram, smqp_qtable.
module stack_and_multi_queue_pool_top
    import smqp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [QIDX_W-1:0]        i_queue_index,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_data_valid,
    output logic signed [DATA_W-1:0] o_data
);

    // control state
    t_state r_state, n_state;
    t_ptr   r_free_head, n_free_head;
    logic   r_free_ne, n_free_ne;
    t_cnt   r_fresh_count, n_fresh_count;
    t_ptr   r_stack_top, n_stack_top;
    logic   r_stack_ne, n_stack_ne;
    t_val   r_held, n_held;
    logic   r_out_valid, n_out_valid;

    // transaction and result payload
    t_opcode           r_op;
    logic [DATA_W-1:0] r_value;
    t_qsel             r_q;
    t_ptr              r_link_addr, n_link_addr;
    t_ptr              r_link_data, n_link_data;
    t_status           r_status, n_status;
    logic              r_data_valid, n_data_valid;
    logic [DATA_W-1:0] r_data, n_data;

    // memory and table ports
    logic     val_wr_en, link_wr_en, rd_en;
    t_ptr     val_wr_addr, link_wr_addr, link_wr_data, rd_addr;
    t_val     val_wr_data, val_rd;
    t_ptr     link_rd;
    t_qsel    q_addr;
    t_qentry  qent;
    t_qupdate qupd;

    logic   in_acc, out_free, exec_go;
    logic   take_ok;
    t_ptr   take_n;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign exec_go  = (r_state == S_EXEC) && out_free;

    // node memories
    smqp_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_NODES)) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_wr_en),
        .i_wr_addr (val_wr_addr),
        .i_wr_data (val_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (val_rd)
    );

    smqp_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rd)
    );

    // queue table, addressed by the incoming transaction while idle
    assign q_addr = (r_state == S_IDLE) ? i_queue_index[QSEL_W-1:0] : r_q;

    smqp_qtable u_qtable (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (q_addr),
        .i_upd   (qupd),
        .o_entry (qent)
    );

    // read address chosen on accept
    always_comb begin
        rd_en = in_acc;
        case (t_opcode'(i_opcode))
            OP_PUSH, OP_ENQ: rd_addr = r_free_head;
            OP_POP:          rd_addr = r_stack_top;
            OP_DEQ:          rd_addr = qent.head;
            default:         rd_addr = r_free_head;
        endcase
    end

    // node allocation: free list first, then never-used nodes
    always_comb begin
        take_ok = 1'b0;
        take_n  = r_free_head;
        if (r_free_ne) begin
            take_ok = 1'b1;
        end else if (r_fresh_count < t_cnt'(POOL_NODES)) begin
            take_ok = 1'b1;
            take_n  = r_fresh_count[PTR_W-1:0];
        end
    end

    // next state, list updates and result
    always_comb begin
        n_state       = r_state;
        n_free_head   = r_free_head;
        n_free_ne     = r_free_ne;
        n_fresh_count = r_fresh_count;
        n_stack_top   = r_stack_top;
        n_stack_ne    = r_stack_ne;
        n_held        = r_held;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_link_addr   = r_link_addr;
        n_link_data   = r_link_data;
        n_status      = r_status;
        n_data_valid  = r_data_valid;
        n_data        = r_data;
        val_wr_en     = 1'b0;
        val_wr_addr   = take_n;
        val_wr_data   = to_node(r_value);
        link_wr_en    = 1'b0;
        link_wr_addr  = take_n;
        link_wr_data  = take_n;
        qupd          = '0;
        qupd.head     = take_n;
        qupd.tail     = take_n;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                if (exec_go) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_status     = ST_OK;
                    n_data_valid = 1'b0;
                    n_data       = '0;
                    case (r_op)
                        OP_PUSH, OP_ENQ: begin
                            if (!take_ok) begin
                                n_status = ST_POOL_FULL;
                            end else begin
                                // unlink the taken node from the free list
                                if (r_free_ne) begin
                                    if (link_rd == r_free_head) begin
                                        n_free_ne = 1'b0;
                                    end else begin
                                        n_free_head = link_rd;
                                    end
                                end else begin
                                    n_fresh_count = r_fresh_count + t_cnt'(1);
                                end
                                val_wr_en  = 1'b1;
                                link_wr_en = 1'b1;
                                if (r_op == OP_PUSH) begin
                                    link_wr_data = r_stack_ne ? r_stack_top : take_n;
                                    n_stack_top  = take_n;
                                    n_stack_ne   = 1'b1;
                                end else begin
                                    val_wr_data  = r_held;
                                    qupd.wr_tail = 1'b1;
                                    if (qent.nonempty) begin
                                        // old tail must point at the new node
                                        n_link_addr = qent.tail;
                                        n_link_data = take_n;
                                        n_state     = S_LINK;
                                    end else begin
                                        qupd.wr_head = 1'b1;
                                        qupd.set_ne  = 1'b1;
                                    end
                                end
                            end
                        end

                        OP_POP: begin
                            if (!r_stack_ne) begin
                                n_status = ST_STACK_EMPTY;
                            end else begin
                                n_held = val_rd;
                                if (link_rd == r_stack_top) begin
                                    n_stack_ne = 1'b0;
                                end else begin
                                    n_stack_top = link_rd;
                                end
                                // release the old top
                                link_wr_en   = 1'b1;
                                link_wr_addr = r_stack_top;
                                link_wr_data = r_free_ne ? r_free_head : r_stack_top;
                                n_free_head  = r_stack_top;
                                n_free_ne    = 1'b1;
                            end
                        end

                        OP_DEQ: begin
                            if (!qent.nonempty) begin
                                n_status = ST_QUEUE_EMPTY;
                            end else begin
                                n_data_valid = 1'b1;
                                n_data       = widen(val_rd);
                                if (qent.head == qent.tail) begin
                                    qupd.clr_ne = 1'b1;
                                end else begin
                                    qupd.wr_head = 1'b1;
                                    qupd.head    = link_rd;
                                end
                                // release the old head
                                link_wr_en   = 1'b1;
                                link_wr_addr = qent.head;
                                link_wr_data = r_free_ne ? r_free_head : qent.head;
                                n_free_head  = qent.head;
                                n_free_ne    = 1'b1;
                            end
                        end

                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_LINK: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_link_addr;
                link_wr_data = r_link_data;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_head   <= '0;
            r_free_ne     <= 1'b0;
            r_fresh_count <= '0;
            r_stack_top   <= '0;
            r_stack_ne    <= 1'b0;
            r_held        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_head   <= n_free_head;
            r_free_ne     <= n_free_ne;
            r_fresh_count <= n_fresh_count;
            r_stack_top   <= n_stack_top;
            r_stack_ne    <= n_stack_ne;
            r_held        <= n_held;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= t_opcode'(i_opcode);
            r_value <= i_value;
            r_q     <= i_queue_index[QSEL_W-1:0];
        end
        r_link_addr  <= n_link_addr;
        r_link_data  <= n_link_data;
        r_status     <= n_status;
        r_data_valid <= n_data_valid;
        r_data       <= n_data;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_data_valid = r_data_valid;
    assign o_data       = r_data;

endmodule
